[rtl/twf_pkg.sv]
// Shared types and constants for the traveling-wave force accumulator.
package twf_pkg;

	localparam int SUM_COUNT = 12;

	localparam logic [1:0] CMD_ATOM = 2'd0;
	localparam logic [1:0] CMD_STEP = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	localparam logic [2:0] REG_AMP_X   = 3'd0;
	localparam logic [2:0] REG_AMP_Y   = 3'd1;
	localparam logic [2:0] REG_AMP_Z   = 3'd2;
	localparam logic [2:0] REG_WAVES_X = 3'd3;
	localparam logic [2:0] REG_WAVES_Y = 3'd4;
	localparam logic [2:0] REG_IBOX_X  = 3'd5;
	localparam logic [2:0] REG_IBOX_Y  = 3'd6;
	localparam logic [2:0] REG_FREQ_DT = 3'd7;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [31:0] PI_Q30  = 32'd3373259426;

	// exact reciprocal multipliers for dividends below 2^31
	localparam int SH_42 = 37;
	localparam int SH_20 = 36;
	localparam int SH_6  = 34;
	localparam int SH_56 = 37;
	localparam int SH_30 = 36;
	localparam int SH_12 = 35;
	localparam logic [31:0] M_42 = 32'(((64'd1 << SH_42) + 64'd41) / 64'd42);
	localparam logic [31:0] M_20 = 32'(((64'd1 << SH_20) + 64'd19) / 64'd20);
	localparam logic [31:0] M_6  = 32'(((64'd1 << SH_6) + 64'd5) / 64'd6);
	localparam logic [31:0] M_56 = 32'(((64'd1 << SH_56) + 64'd55) / 64'd56);
	localparam logic [31:0] M_30 = 32'(((64'd1 << SH_30) + 64'd29) / 64'd30);
	localparam logic [31:0] M_12 = 32'(((64'd1 << SH_12) + 64'd11) / 64'd12);

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

endpackage

[rtl/twf_div.sv]
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor.
module twf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  twf_pkg::div_req_t req,
	output twf_pkg::div_rsp_t rsp
);
	import twf_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] den_q;
	logic [32:0] sh;
	logic        fits;

	assign sh   = {rem_q, quo_q[63]};
	assign fits = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(sh - {1'b0, den_q}) : sh[31:0];
			quo_q <= {quo_q[62:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[rtl/traveling_wave_force_fourier_accum_unit.sv]
// Traveling-wave force drive with twelve Fourier sums, top level.
//
// Input channel (in_valid/in_ready) carries one command word: an atom, an
// end of step, or a read of one averaged sum. Output channel (out_valid/
// out_ready) returns one word for an atom or a read; end of step and the
// unused command return nothing and leave the sequencer idle.
// An atom of the driven group runs on one shared 33x33 multiplier under a
// microstep counter: seven products for the phase, a sine and cosine
// polynomial chain (its divides done as reciprocal products), twelve sum
// terms and three forces, then the output register is loaded.
// An atom outside the group skips the chain and answers with zero forces.
// A read runs the bit-serial divider on the sum; with a zero step count or
// an index above eleven it answers without the divider.
// One item at a time: in_ready is high only while the sequencer is idle.
// The output register holds a word while out_ready is low and the next item
// is still accepted; a finished item waits for a free output register.
// Reset clears the sums, the step count, configuration and the handshakes.
// Configuration writes take effect at once and belong to idle periods.
module traveling_wave_force_fourier_accum_unit #(
	parameter int ANGLE_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic signed [31:0] eq_x,
	input  logic signed [31:0] eq_y,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic               in_group,
	input  logic [31:0]        step_number,
	input  logic [3:0]         component_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic signed [63:0] average_value
);
	import twf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ATOM = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [4:0] OP_NONE = 5'd0;
	localparam logic [4:0] OP_MX   = 5'd1;
	localparam logic [4:0] OP_MY   = 5'd2;
	localparam logic [4:0] OP_FS   = 5'd3;
	localparam logic [4:0] OP_XL   = 5'd4;
	localparam logic [4:0] OP_XH   = 5'd5;
	localparam logic [4:0] OP_YL   = 5'd6;
	localparam logic [4:0] OP_YH   = 5'd7;
	localparam logic [4:0] OP_XR   = 5'd8;
	localparam logic [4:0] OP_X2   = 5'd9;
	localparam logic [4:0] OP_S1   = 5'd10;
	localparam logic [4:0] OP_S2   = 5'd11;
	localparam logic [4:0] OP_S3   = 5'd12;
	localparam logic [4:0] OP_S4   = 5'd13;
	localparam logic [4:0] OP_S5   = 5'd14;
	localparam logic [4:0] OP_S6   = 5'd15;
	localparam logic [4:0] OP_C1   = 5'd16;
	localparam logic [4:0] OP_C2   = 5'd17;
	localparam logic [4:0] OP_C3   = 5'd18;
	localparam logic [4:0] OP_C4   = 5'd19;
	localparam logic [4:0] OP_C5   = 5'd20;
	localparam logic [4:0] OP_C6   = 5'd21;
	localparam logic [4:0] OP_SUM  = 5'd22;
	localparam logic [4:0] OP_FX   = 5'd23;
	localparam logic [4:0] OP_FY   = 5'd24;
	localparam logic [4:0] OP_FZ   = 5'd25;

	localparam logic [5:0] UC_FOLD  = 6'd25;
	localparam logic [5:0] UC_SUM0  = 6'd26;
	localparam logic [5:0] UC_LAST  = 6'd41;

	function automatic logic signed [15:0] to_q15(input logic [30:0] v);
		logic [16:0] r;
		r = 17'((32'(v) + 32'd16384) >> 15);
		return (r > 17'd32767) ? 16'sd32767 : 16'(r);
	endfunction

	// configuration
	logic signed [31:0] amp_x_q, amp_y_q, amp_z_q;
	logic signed [7:0]  waves_x_q, waves_y_q;
	logic [31:0]        ibox_x_q, ibox_y_q, freq_dt_q;

	// item and state
	logic [1:0]         state_q;
	logic [5:0]         uc_q;
	logic signed [31:0] eqx_q, eqy_q;
	logic signed [31:0] pv_q [6];
	logic [31:0]        step_q;
	logic [63:0]        sums_q [SUM_COUNT];
	logic [31:0]        step_count_q;
	logic               neg_q;

	// datapath registers
	logic signed [39:0] px_q, py_q;
	logic [47:0]        ph_q;
	logic [1:0]         quad_q;
	logic               swap_q;
	logic [29:0]        x_q, x2_q, ps_q, pc_q;
	logic [30:0]        ts_q, tc_q;
	logic signed [15:0] s0_q, c0_q, cs_q, sn_q;
	logic signed [31:0] fx_q, fy_q, fz_q;
	logic signed [63:0] avg_q;

	// shared multiplier and its pipeline register
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod;
	logic [4:0]         op_nx;
	logic [3:0]         sidx_nx;
	logic signed [65:0] prod_s1;
	logic [65:0]        pu;
	logic [4:0]         op_s1;
	logic [3:0]         sidx_s1;

	logic        in_acc;
	logic        out_load;
	logic [31:0] ang;
	logic [29:0] th;
	logic [23:0] px_hi, py_hi;
	logic [3:0]  jsum;
	logic        use_sin;
	logic [2:0]  vsel;
	logic [63:0] rd_sum;
	logic        rd_neg;
	div_req_t    dreq;
	div_rsp_t    drsp;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid || out_ready);

	assign ang   = 32'(ph_q[47 -: ANGLE_BITS]) << (32 - ANGLE_BITS);
	assign th    = ang[29] ? 30'(Q30_ONE - {1'b0, ang[29:0]}) : ang[29:0];
	assign px_hi = {{8{px_q[39]}}, px_q[39:24]};
	assign py_hi = {{8{py_q[39]}}, py_q[39:24]};
	assign jsum  = 4'(uc_q - UC_SUM0);
	assign pu    = prod_s1;
	assign prod  = ma * mb;

	assign rd_sum = sums_q[component_index];
	assign rd_neg = rd_sum[63];

	// pick the sum term: pos*cos, pos*sin, vel*cos, vel*sin, three axes each
	always_comb begin
		case (jsum)
			4'd0:    begin use_sin = 1'b0; vsel = 3'd0; end
			4'd1:    begin use_sin = 1'b0; vsel = 3'd1; end
			4'd2:    begin use_sin = 1'b0; vsel = 3'd2; end
			4'd3:    begin use_sin = 1'b1; vsel = 3'd0; end
			4'd4:    begin use_sin = 1'b1; vsel = 3'd1; end
			4'd5:    begin use_sin = 1'b1; vsel = 3'd2; end
			4'd6:    begin use_sin = 1'b0; vsel = 3'd3; end
			4'd7:    begin use_sin = 1'b0; vsel = 3'd4; end
			4'd8:    begin use_sin = 1'b0; vsel = 3'd5; end
			4'd9:    begin use_sin = 1'b1; vsel = 3'd3; end
			4'd10:   begin use_sin = 1'b1; vsel = 3'd4; end
			default: begin use_sin = 1'b1; vsel = 3'd5; end
		endcase
	end

	// issue: operands for the microstep
	always_comb begin
		ma      = '0;
		mb      = '0;
		op_nx   = OP_NONE;
		sidx_nx = jsum;
		if (state_q == ST_ATOM) begin
			case (uc_q)
				6'd0: begin op_nx = OP_MX; ma = 33'(eqx_q); mb = 33'(waves_x_q); end
				6'd1: begin op_nx = OP_MY; ma = 33'(eqy_q); mb = 33'(waves_y_q); end
				6'd2: begin
					op_nx = OP_FS; ma = {1'b0, freq_dt_q}; mb = {1'b0, step_q};
				end
				6'd3: begin
					op_nx = OP_XL; ma = {9'b0, px_q[23:0]}; mb = {1'b0, ibox_x_q};
				end
				6'd4: begin op_nx = OP_XH; ma = {9'b0, px_hi}; mb = {1'b0, ibox_x_q}; end
				6'd5: begin
					op_nx = OP_YL; ma = {9'b0, py_q[23:0]}; mb = {1'b0, ibox_y_q};
				end
				6'd6: begin op_nx = OP_YH; ma = {9'b0, py_hi}; mb = {1'b0, ibox_y_q}; end
				6'd8: begin op_nx = OP_XR; ma = {3'b0, th}; mb = {1'b0, PI_Q30}; end
				6'd10: begin op_nx = OP_X2; ma = {3'b0, x_q}; mb = {3'b0, x_q}; end
				6'd12: begin op_nx = OP_S1; ma = {3'b0, x2_q}; mb = {1'b0, M_42}; end
				6'd13: begin op_nx = OP_C1; ma = {3'b0, x2_q}; mb = {1'b0, M_56}; end
				6'd14: begin op_nx = OP_S2; ma = {3'b0, x2_q}; mb = {2'b0, ts_q}; end
				6'd15: begin op_nx = OP_C2; ma = {3'b0, x2_q}; mb = {2'b0, tc_q}; end
				6'd16: begin op_nx = OP_S3; ma = {3'b0, ps_q}; mb = {1'b0, M_20}; end
				6'd17: begin op_nx = OP_C3; ma = {3'b0, pc_q}; mb = {1'b0, M_30}; end
				6'd18: begin op_nx = OP_S4; ma = {3'b0, x2_q}; mb = {2'b0, ts_q}; end
				6'd19: begin op_nx = OP_C4; ma = {3'b0, x2_q}; mb = {2'b0, tc_q}; end
				6'd20: begin op_nx = OP_S5; ma = {3'b0, ps_q}; mb = {1'b0, M_6}; end
				6'd21: begin op_nx = OP_C5; ma = {3'b0, pc_q}; mb = {1'b0, M_12}; end
				6'd22: begin op_nx = OP_S6; ma = {3'b0, x_q}; mb = {2'b0, ts_q}; end
				6'd23: begin op_nx = OP_C6; ma = {3'b0, x2_q}; mb = {2'b0, tc_q}; end
				6'd38: begin op_nx = OP_FX; ma = 33'(cs_q); mb = 33'(amp_x_q); end
				6'd39: begin op_nx = OP_FY; ma = 33'(cs_q); mb = 33'(amp_y_q); end
				6'd40: begin op_nx = OP_FZ; ma = 33'(cs_q); mb = 33'(amp_z_q); end
				default: begin
					if (uc_q >= UC_SUM0 && uc_q < 6'd38) begin
						op_nx = OP_SUM;
						ma    = use_sin ? 33'(sn_q) : 33'(cs_q);
						mb    = 33'(pv_q[vsel]);
					end
				end
			endcase
		end
	end

	always_comb begin
		dreq.start    = in_acc && (command == CMD_READ) && (component_index < 4'(SUM_COUNT))
			&& (step_count_q != 32'd0);
		dreq.dividend = rd_neg ? (64'd0 - rd_sum) : rd_sum;
		dreq.divisor  = step_count_q;
	end

	twf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			uc_q         <= '0;
			op_s1        <= OP_NONE;
			step_count_q <= '0;
			out_valid    <= 1'b0;
			amp_x_q      <= '0;
			amp_y_q      <= '0;
			amp_z_q      <= '0;
			waves_x_q    <= '0;
			waves_y_q    <= '0;
			ibox_x_q     <= '0;
			ibox_y_q     <= '0;
			freq_dt_q    <= '0;
			for (int k = 0; k < SUM_COUNT; k++) begin
				sums_q[k] <= '0;
			end
		end else begin
			op_s1 <= op_nx;
			if (cfg_we) begin
				case (cfg_index)
					REG_AMP_X:   amp_x_q   <= cfg_data;
					REG_AMP_Y:   amp_y_q   <= cfg_data;
					REG_AMP_Z:   amp_z_q   <= cfg_data;
					REG_WAVES_X: waves_x_q <= cfg_data[7:0];
					REG_WAVES_Y: waves_y_q <= cfg_data[7:0];
					REG_IBOX_X:  ibox_x_q  <= cfg_data;
					REG_IBOX_Y:  ibox_y_q  <= cfg_data;
					REG_FREQ_DT: freq_dt_q <= cfg_data;
					default: ;
				endcase
			end
			if (op_s1 == OP_SUM) begin
				sums_q[sidx_s1] <= sums_q[sidx_s1] + 64'(prod_s1 >>> 15);
			end
			// load a new word, or hold the current one until it is taken
			out_valid <= out_load || (out_valid && !out_ready);
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (command)
							CMD_ATOM: begin
								uc_q    <= '0;
								state_q <= in_group ? ST_ATOM : ST_DONE;
							end
							CMD_STEP: step_count_q <= step_count_q + 32'd1;
							CMD_READ: state_q <= dreq.start ? ST_DIV : ST_DONE;
							default: ;
						endcase
					end
				end
				ST_ATOM: begin
					uc_q <= uc_q + 6'd1;
					if (uc_q == UC_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (drsp.done) begin
						state_q <= ST_DONE;
					end
				end
				default: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		sidx_s1 <= sidx_nx;
		if (in_acc) begin
			eqx_q    <= eq_x;
			eqy_q    <= eq_y;
			pv_q[0]  <= pos_x;
			pv_q[1]  <= pos_y;
			pv_q[2]  <= pos_z;
			pv_q[3]  <= vel_x;
			pv_q[4]  <= vel_y;
			pv_q[5]  <= vel_z;
			step_q   <= step_number;
			ph_q     <= '0;
			fx_q     <= '0;
			fy_q     <= '0;
			fz_q     <= '0;
			neg_q    <= rd_neg;
			if (command == CMD_READ && component_index < 4'(SUM_COUNT)) begin
				avg_q <= rd_sum;
			end else begin
				avg_q <= '0;
			end
		end
		if (state_q == ST_DIV && drsp.done) begin
			avg_q <= neg_q ? (64'd0 - drsp.quotient) : drsp.quotient;
		end
		if (state_q == ST_ATOM && uc_q == 6'd8) begin
			quad_q <= ang[31:30];
			swap_q <= ang[29];
		end
		// fold the first-octant pair back to the full circle
		if (state_q == ST_ATOM && uc_q == UC_FOLD) begin
			case (quad_q)
				2'd0: begin
					cs_q <= swap_q ? s0_q : c0_q;
					sn_q <= swap_q ? c0_q : s0_q;
				end
				2'd1: begin
					cs_q <= swap_q ? -c0_q : -s0_q;
					sn_q <= swap_q ? s0_q : c0_q;
				end
				2'd2: begin
					cs_q <= swap_q ? -s0_q : -c0_q;
					sn_q <= swap_q ? -c0_q : -s0_q;
				end
				default: begin
					cs_q <= swap_q ? c0_q : s0_q;
					sn_q <= swap_q ? -s0_q : -c0_q;
				end
			endcase
		end
		case (op_s1)
			OP_MX: px_q <= prod_s1[39:0];
			OP_MY: py_q <= prod_s1[39:0];
			OP_FS: ph_q <= ph_q - {pu[31:0], 16'b0};
			OP_XL: ph_q <= ph_q + pu[47:0];
			OP_XH: ph_q <= ph_q + {pu[23:0], 24'b0};
			OP_YL: ph_q <= ph_q + pu[47:0];
			OP_YH: ph_q <= ph_q + {pu[23:0], 24'b0};
			OP_XR: x_q  <= pu[60:31];
			OP_X2: x2_q <= pu[59:30];
			OP_S1: ts_q <= Q30_ONE - 31'(pu >> SH_42);
			OP_C1: tc_q <= Q30_ONE - 31'(pu >> SH_56);
			OP_S2: ps_q <= 30'(pu >> 30);
			OP_C2: pc_q <= 30'(pu >> 30);
			OP_S3: ts_q <= Q30_ONE - 31'(pu >> SH_20);
			OP_C3: tc_q <= Q30_ONE - 31'(pu >> SH_30);
			OP_S4: ps_q <= 30'(pu >> 30);
			OP_C4: pc_q <= 30'(pu >> 30);
			OP_S5: ts_q <= Q30_ONE - 31'(pu >> SH_6);
			OP_C5: tc_q <= Q30_ONE - 31'(pu >> SH_12);
			OP_S6: s0_q <= to_q15(31'(pu >> 30));
			OP_C6: c0_q <= to_q15(Q30_ONE - 31'(pu >> 31));
			OP_FX: fx_q <= 32'(prod_s1 >>> 15);
			OP_FY: fy_q <= 32'(prod_s1 >>> 15);
			OP_FZ: fz_q <= 32'(prod_s1 >>> 15);
			default: ;
		endcase
		if (out_load) begin
			force_x       <= fx_q;
			force_y       <= fy_q;
			force_z       <= fz_q;
			average_value <= avg_q;
		end
	end

endmodule

[rtl/twf_checker.sv]
// Port-level checks for the traveling-wave force accumulator, bound to the top.
module twf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         command,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] force_x,
	input logic signed [31:0] force_y,
	input logic signed [31:0] force_z,
	input logic signed [63:0] average_value
);
	import twf_pkg::*;

	// in_ready is low in the cycle after an atom or read word is taken
	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (command == CMD_ATOM || command == CMD_READ) |=> !in_ready)
		else $error("block ready right after an atom or read word");

	// end of step does not occupy the block and leaves it free
	a_step_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_STEP |=> in_ready)
		else $error("block busy after end-of-step word");

	// a result is either a force word or an average word, never both
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (force_x == 0 && force_y == 0 && force_z == 0) || average_value == 0)
		else $error("result carries both forces and an average");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(average_value) && $stable(force_x))
		else $error("stalled result changed");

endmodule

bind traveling_wave_force_fourier_accum_unit twf_checker u_twf_checker (.*);

[sim/traveling_wave_force_fourier_accum_unit_tb.sv]
// Self-checking testbench for the traveling-wave force and Fourier sum unit.
module traveling_wave_force_fourier_accum_unit_tb;
	import twf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam logic [63:0] ONE_Q30 = 64'h4000_0000;
	localparam logic [63:0] PI_Q30_W = 64'd3373259426;

	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] eqx, eqy, px, py, pz, vx, vy, vz;
		logic        grp;
		logic [31:0] stepn;
		logic [3:0]  idx;
		bit          typed;
		logic [31:0] tfx, tfy, tfz;
		logic [63:0] tavg;
	} word_t;

	typedef struct {
		logic [31:0] fx, fy, fz;
		logic [63:0] avg;
	} answer_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] command = '0;
	logic signed [31:0] eq_x = 0, eq_y = 0, pos_x = 0, pos_y = 0, pos_z = 0;
	logic signed [31:0] vel_x = 0, vel_y = 0, vel_z = 0;
	logic in_group = 0;
	logic [31:0] step_number = '0;
	logic [3:0] component_index = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] force_x, force_y, force_z;
	logic signed [63:0] average_value;

	traveling_wave_force_fourier_accum_unit dut (.*);

	always #10 clk = ~clk;

	// model state
	logic [31:0] m_amp [3];
	logic [7:0]  m_waves_x, m_waves_y;
	logic [31:0] m_ibox_x, m_ibox_y, m_freq_dt;
	logic [63:0] m_sums [SUM_COUNT];
	logic [31:0] m_steps;

	answer_t answers_due [$];
	word_t   dir_words [$];
	int errors = 0;
	int n_atoms = 0, n_reads = 0, n_answers = 0;
	bit quiet = 0;

	function automatic int round_q15(input logic [63:0] v);
		logic [63:0] r;
		r = (v + 64'd16384) >> 15;
		return (r > 64'd32767) ? 32767 : int'(r);
	endfunction

	function automatic void cos_sin(input logic [31:0] a, output int co, output int si);
		logic [63:0] f, th, x, x2, t;
		int s0, c0, tmp;
		bit sw;
		f = {34'b0, a[29:0]};
		sw = f >= 64'h2000_0000;
		th = sw ? ONE_Q30 - f : f;
		x = (th * PI_Q30_W) >> 31;
		x2 = (x * x) >> 30;
		t = ONE_Q30 - x2 / 42;
		t = ONE_Q30 - ((x2 * t) >> 30) / 20;
		t = ONE_Q30 - ((x2 * t) >> 30) / 6;
		s0 = round_q15((x * t) >> 30);
		t = ONE_Q30 - x2 / 56;
		t = ONE_Q30 - ((x2 * t) >> 30) / 30;
		t = ONE_Q30 - ((x2 * t) >> 30) / 12;
		c0 = round_q15(ONE_Q30 - ((x2 * t) >> 30) / 2);
		if (sw) begin
			tmp = s0; s0 = c0; c0 = tmp;
		end
		case (a[31:30])
			2'd0: begin co = c0;  si = s0;  end
			2'd1: begin co = -s0; si = c0;  end
			2'd2: begin co = -c0; si = -s0; end
			default: begin co = s0; si = -c0; end
		endcase
	endfunction

	function automatic logic [63:0] scale_q15(input int k, input logic [63:0] v);
		longint pr;
		pr = longint'(k) * longint'(v);
		return pr >>> 15;
	endfunction

	function automatic logic [63:0] sx32(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	// compute the answer for one word and advance the sums and step count
	function automatic bit predict_answer(input word_t w, output answer_t r);
		logic [63:0] ph, s, mag, q;
		logic [63:0] p [3], v [3];
		int c, sn;
		r = '{0, 0, 0, 0};
		case (w.cmd)
			CMD_STEP: begin
				m_steps = m_steps + 32'd1;
				return 0;
			end
			CMD_READ: begin
				if (w.idx < SUM_COUNT) begin
					s = m_sums[w.idx];
					if (m_steps == 0) r.avg = s;
					else begin
						mag = s[63] ? -s : s;
						q = mag / {32'b0, m_steps};
						r.avg = s[63] ? -q : q;
					end
				end
				return 1;
			end
			CMD_ATOM: begin
				if (w.grp) begin
					ph = sx32(w.eqx) * {{56{m_waves_x[7]}}, m_waves_x} * {32'b0, m_ibox_x};
					ph += sx32(w.eqy) * {{56{m_waves_y[7]}}, m_waves_y} * {32'b0, m_ibox_y};
					ph -= ({32'b0, m_freq_dt} * {32'b0, w.stepn}) << 16;
					cos_sin({ph[47:32], 16'b0}, c, sn);
					p[0] = sx32(w.px); p[1] = sx32(w.py); p[2] = sx32(w.pz);
					v[0] = sx32(w.vx); v[1] = sx32(w.vy); v[2] = sx32(w.vz);
					for (int k = 0; k < 3; k++) begin
						m_sums[k]     += scale_q15(c, p[k]);
						m_sums[k + 3] += scale_q15(sn, p[k]);
						m_sums[k + 6] += scale_q15(c, v[k]);
						m_sums[k + 9] += scale_q15(sn, v[k]);
					end
					r.fx = 32'(scale_q15(c, sx32(m_amp[0])));
					r.fy = 32'(scale_q15(c, sx32(m_amp[1])));
					r.fz = 32'(scale_q15(c, sx32(m_amp[2])));
				end
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	// drive one register write; the caller drops cfg_we after the last one
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_AMP_X:   m_amp[0] = val;
			REG_AMP_Y:   m_amp[1] = val;
			REG_AMP_Z:   m_amp[2] = val;
			REG_WAVES_X: m_waves_x = val[7:0];
			REG_WAVES_Y: m_waves_y = val[7:0];
			REG_IBOX_X:  m_ibox_x = val;
			REG_IBOX_Y:  m_ibox_y = val;
			default:     m_freq_dt = val;
		endcase
		@(posedge clk);
	endtask

	// drop valid and let the block drain before touching registers
	task automatic wait_drained();
		in_valid <= 0;
		@(posedge clk);
		while (answers_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic send_word(input word_t w);
		answer_t r;
		bit acc;
		in_valid <= 1;
		command <= w.cmd;
		eq_x <= w.eqx; eq_y <= w.eqy;
		pos_x <= w.px; pos_y <= w.py; pos_z <= w.pz;
		vel_x <= w.vx; vel_y <= w.vy; vel_z <= w.vz;
		in_group <= w.grp;
		step_number <= w.stepn;
		component_index <= w.idx;
		do begin
			@(negedge clk);
			acc = in_ready;
			@(posedge clk);
		end while (!acc);
		if (predict_answer(w, r)) begin
			if (w.typed) r = '{w.tfx, w.tfy, w.tfz, w.tavg};
			answers_due.push_back(r);
		end
		if (w.cmd == CMD_ATOM) n_atoms++;
		if (w.cmd == CMD_READ) n_reads++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	function automatic word_t rand_word();
		word_t w;
		int sel;
		sel = $urandom_range(0, 99);
		w.cmd = sel < 62 ? CMD_ATOM : sel < 74 ? CMD_STEP : sel < 95 ? CMD_READ : CMD_NONE;
		w.eqx = $urandom; w.eqy = $urandom;
		w.px = $urandom; w.py = $urandom; w.pz = $urandom;
		w.vx = $urandom; w.vy = $urandom; w.vz = $urandom;
		w.grp = $urandom_range(0, 9) != 0;
		w.stepn = $urandom;
		w.idx = $urandom_range(0, 15);
		w.typed = 0;
		return w;
	endfunction

	function automatic word_t mk(input logic [1:0] cmd, input logic [31:0] val,
			input logic grp, input logic [3:0] idx, input bit typed);
		word_t w;
		w.cmd = cmd;
		w.eqx = val; w.eqy = ~val;
		w.px = val; w.py = ~val; w.pz = val ^ 32'h5555_5555;
		w.vx = ~val; w.vy = val; w.vz = val ^ 32'hAAAA_AAAA;
		w.grp = grp;
		w.stepn = val;
		w.idx = idx;
		w.typed = typed;
		w.tfx = 0; w.tfy = 0; w.tfz = 0; w.tavg = 0;
		return w;
	endfunction

	// output side: random ready bursts, compare at the falling edge
	int stall_left = 0;
	always @(posedge clk) begin
		if (quiet) out_ready <= 1;
		else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 0;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left <= $urandom_range(0, 9);
			out_ready <= 0;
		end else out_ready <= 1;
	end

	always @(negedge clk) begin
		answer_t e;
		if (arst_n && out_valid && out_ready) begin
			n_answers++;
			if (answers_due.size() == 0) begin
				$error("unexpected word: force_x %h avg %h", force_x, average_value);
				errors++;
			end else begin
				e = answers_due.pop_front();
				if (force_x !== e.fx) begin
					$error("force_x expected %h actual %h", e.fx, force_x); errors++;
				end
				if (force_y !== e.fy) begin
					$error("force_y expected %h actual %h", e.fy, force_y); errors++;
				end
				if (force_z !== e.fz) begin
					$error("force_z expected %h actual %h", e.fz, force_z); errors++;
				end
				if (average_value !== e.avg) begin
					$error("average_value expected %h actual %h", e.avg, average_value);
					errors++;
				end
			end
		end
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [31:0] cfg [8];
		m_amp = '{0, 0, 0};
		m_waves_x = 0; m_waves_y = 0;
		m_ibox_x = 0; m_ibox_y = 0; m_freq_dt = 0;
		m_steps = 0;
		foreach (m_sums[k]) m_sums[k] = 0;

		// reads after reset, extremes, ignored command, out-of-range index
		dir_words.push_back(mk(CMD_READ, 32'h0, 0, 4'd0, 1));
		dir_words.push_back(mk(CMD_READ, 32'h0, 0, 4'd11, 1));
		dir_words.push_back(mk(CMD_ATOM, 32'h7FFF_FFFF, 0, 4'd0, 1));
		dir_words.push_back(mk(CMD_ATOM, 32'h8000_0000, 1, 4'd0, 1));
		dir_words.push_back(mk(CMD_ATOM, 32'h7FFF_FFFF, 1, 4'd0, 1));
		dir_words.push_back(mk(CMD_NONE, 32'hFFFF_FFFF, 1, 4'd0, 0));
		dir_words.push_back(mk(CMD_READ, 32'h0, 0, 4'd12, 1));
		dir_words.push_back(mk(CMD_READ, 32'h0, 0, 4'd15, 1));
		for (int k = 0; k < 12; k++) dir_words.push_back(mk(CMD_READ, 0, 0, 4'(k), 0));
		dir_words.push_back(mk(CMD_STEP, 0, 0, 0, 0));
		dir_words.push_back(mk(CMD_STEP, 0, 0, 0, 0));
		dir_words.push_back(mk(CMD_STEP, 0, 0, 0, 0));
		dir_words.push_back(mk(CMD_READ, 0, 0, 4'd0, 0));
		dir_words.push_back(mk(CMD_READ, 0, 0, 4'd5, 0));

		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (dir_words[k]) send_word(dir_words[k]);

		for (int ph = 0; ph < 5; ph++) begin
			wait_drained();
			case (ph)
				1: cfg = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd127, 32'd127,
					32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
				2: cfg = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h80, 32'h80,
					32'h0, 32'h0, 32'h0};
				default: foreach (cfg[k]) cfg[k] = $urandom;
			endcase
			for (int k = 0; k < 8; k++) write_reg(3'(k), cfg[k]);
			cfg_we <= 0;
			if (ph == 4) quiet = 1;
			repeat (230) send_word(rand_word());
		end

		in_valid <= 0;
		@(posedge clk);
		while (answers_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Covered %0d atom words and %0d reads over five register settings,",
			n_atoms, n_reads);
		$display("%0d answers checked, %0d mismatches.", n_answers, errors);
		if (errors == 0 && answers_due.size() == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule

[filelist.f]
rtl/twf_pkg.sv
rtl/twf_div.sv
rtl/traveling_wave_force_fourier_accum_unit.sv
rtl/twf_checker.sv
sim/traveling_wave_force_fourier_accum_unit_tb.sv
